/* rtl/lru_replacement_order_macros.svh */
// Assertion macros shared by the checker of the LRU replacement list.
`ifndef LRU_REPLACEMENT_ORDER_MACROS_SVH
`define LRU_REPLACEMENT_ORDER_MACROS_SVH

// Check a property while out of reset.
`define LRU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define LRU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/lru_pkg.sv */
// Shared types and constants of the LRU replacement list.
`timescale 1ns / 1ps

package lru_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_BITS_DEF = 32;

  typedef enum logic [1:0] {
    MODE_TOUCH  = 2'd0,
    MODE_VICTIM = 2'd1,
    MODE_ERASE  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_MOVE,
    OP_APPEND,
    OP_REMOVE,
    OP_POP
  } op_t;

  // Controller to datapath.
  typedef struct packed {
    logic    load;
    logic    apply;
    op_t     op;
    status_t status;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic hit;
    logic empty;
    logic full;
  } stat_t;

endpackage

/* rtl/lru_ctrl.sv */
// Controller of the LRU replacement list: sequences accept and apply, owns out_valid.
`timescale 1ns / 1ps

module lru_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_mode,
  output logic           out_valid,
  input  logic           out_ready,
  input  lru_pkg::stat_t stat,
  output lru_pkg::cmd_t  cmd
);

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_t;

  state_t         state_r;
  lru_pkg::mode_t mode_r;
  logic           out_valid_r;
  logic           out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cmd.load   = in_valid && (state_r == S_IDLE);
    cmd.apply  = (state_r == S_APPLY) && out_free;
    cmd.op     = lru_pkg::OP_NONE;
    cmd.status = lru_pkg::ST_OK;
    case (mode_r)
      lru_pkg::MODE_TOUCH: begin
        if (stat.hit) begin
          cmd.op = lru_pkg::OP_MOVE;
        end else if (stat.full) begin
          cmd.status = lru_pkg::ST_FULL;
        end else begin
          cmd.op = lru_pkg::OP_APPEND;
        end
      end
      lru_pkg::MODE_VICTIM: begin
        if (stat.empty) begin
          cmd.status = lru_pkg::ST_EMPTY;
        end else begin
          cmd.op = lru_pkg::OP_POP;
        end
      end
      lru_pkg::MODE_ERASE: begin
        if (stat.hit) begin
          cmd.op = lru_pkg::OP_REMOVE;
        end else begin
          cmd.status = lru_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        cmd.op = lru_pkg::OP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mode_r      <= lru_pkg::MODE_NONE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
          end
          if (in_valid) begin
            mode_r  <= lru_pkg::mode_t'(in_mode);
            state_r <= S_APPLY;
          end
        end
        S_APPLY: begin
          // hold here until the result register is free
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/lru_datapath.sv */
// Datapath of the LRU replacement list: key cells, match vector, shift and result registers.
`timescale 1ns / 1ps

module lru_datapath #(
  parameter int CAPACITY = lru_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = lru_pkg::KEY_BITS_DEF,
  localparam int CW      = $clog2(CAPACITY + 1),
  localparam int LW      = $clog2(CAPACITY)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lru_pkg::cmd_t       cmd,
  input  logic [KEY_BITS-1:0] in_key,
  output lru_pkg::stat_t      stat,
  output logic [1:0]          out_status,
  output logic [KEY_BITS-1:0] out_victim_key,
  output logic [CW-1:0]       out_key_count
);

  logic [KEY_BITS-1:0] cell_r   [CAPACITY];
  logic [KEY_BITS-1:0] cell_nxt [CAPACITY];
  logic [KEY_BITS-1:0] cell_up  [CAPACITY];
  logic [CAPACITY-1:0] occ_r;
  logic [CAPACITY-1:0] occ_nxt;
  logic [CAPACITY:0]   occ_up;
  logic [CAPACITY:0]   occ_dn;
  logic [CAPACITY-1:0] match_r;
  logic [CAPACITY-1:0] last;
  logic [CAPACITY-1:0] first_free;
  logic [CAPACITY-1:0] shift;
  logic [CAPACITY-1:0] pre [LW+1];
  logic [KEY_BITS-1:0] key_r;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;
  logic [1:0]          status_r;
  logic [KEY_BITS-1:0] victim_r;
  logic [CW-1:0]       count_out_r;

  assign stat.hit   = |match_r;
  assign stat.empty = ~occ_r[0];
  assign stat.full  = occ_r[CAPACITY-1];

  assign occ_up = {1'b0, occ_r};
  assign occ_dn = {occ_r, 1'b1};

  // Mark every cell at or above the matching cell, log-depth prefix OR.
  assign pre[0] = match_r;
  for (genvar s = 0; s < LW; s++) begin : g_pre
    assign pre[s+1] = pre[s] | (pre[s] << (1 << s));
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign last[i]       = occ_r[i] & ~occ_up[i+1];
    assign first_free[i] = ~occ_r[i] & occ_dn[i];
    if (i < CAPACITY - 1) begin : g_up
      assign cell_up[i] = cell_r[i+1];
    end else begin : g_top
      assign cell_up[i] = cell_r[i];
    end
  end

  assign shift = (cmd.op == lru_pkg::OP_POP) ? '1 : pre[LW];

  always_comb begin
    occ_nxt   = occ_r;
    count_nxt = count_r;
    for (int i = 0; i < CAPACITY; i++) begin
      cell_nxt[i] = cell_r[i];
    end
    case (cmd.op)
      lru_pkg::OP_MOVE: begin
        // close the gap and put the key back on the most recent cell
        for (int i = 0; i < CAPACITY; i++) begin
          if (last[i]) begin
            cell_nxt[i] = key_r;
          end else if (shift[i]) begin
            cell_nxt[i] = cell_up[i];
          end
        end
      end
      lru_pkg::OP_APPEND: begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (first_free[i]) begin
            cell_nxt[i] = key_r;
          end
        end
        occ_nxt   = occ_r | first_free;
        count_nxt = count_r + CW'(1);
      end
      lru_pkg::OP_REMOVE, lru_pkg::OP_POP: begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (shift[i]) begin
            cell_nxt[i] = cell_up[i];
          end
        end
        occ_nxt   = occ_r & ~last;
        count_nxt = count_r - CW'(1);
      end
      default: begin
        occ_nxt = occ_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r   <= '0;
      count_r <= '0;
    end else if (cmd.apply) begin
      occ_r   <= occ_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_key;
      for (int i = 0; i < CAPACITY; i++) begin
        match_r[i] <= occ_r[i] && (cell_r[i] == in_key);
      end
    end
    if (cmd.apply) begin
      for (int i = 0; i < CAPACITY; i++) begin
        cell_r[i] <= cell_nxt[i];
      end
      status_r    <= cmd.status;
      victim_r    <= (cmd.op == lru_pkg::OP_POP) ? cell_r[0] : '0;
      count_out_r <= count_nxt;
    end
  end

  assign out_status     = status_r;
  assign out_victim_key = victim_r;
  assign out_key_count  = count_out_r;

endmodule

/* rtl/lru_replacement_order.sv */
// Per request, the accept edge registers a compare of the key against every cell, and the
// apply edge shifts the cells and loads the result register once that register is free.
// No request is accepted before the last one's apply; out_valid rises at its apply edge.
// While a result waits on out_ready, one more request is accepted and held before its apply.
// Reset clears the occupancy bits and the key count; the block is ready the cycle after.
`timescale 1ns / 1ps

// Top level of the LRU replacement list.
module lru_replacement_order #(
  parameter int CAPACITY = lru_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = lru_pkg::KEY_BITS_DEF,
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_mode,
  input  logic [KEY_BITS-1:0] in_key,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic [KEY_BITS-1:0] out_victim_key,
  output logic [CW-1:0]       out_key_count
);

  lru_pkg::cmd_t  cmd;
  lru_pkg::stat_t stat;

  lru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lru_datapath #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_key         (in_key),
    .stat           (stat),
    .out_status     (out_status),
    .out_victim_key (out_victim_key),
    .out_key_count  (out_key_count)
  );

endmodule

/* rtl/lru_checker.sv */
// Port-level checker of the LRU replacement list and its bind.
`timescale 1ns / 1ps
`include "lru_replacement_order_macros.svh"

module lru_checker #(
  parameter int CAPACITY = lru_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = lru_pkg::KEY_BITS_DEF,
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [1:0]          out_status,
  input logic [KEY_BITS-1:0] out_victim_key,
  input logic [CW-1:0]       out_key_count
);

  `LRU_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "out_valid after reset")

  `LRU_ASSERT(a_count_range, out_valid |-> out_key_count <= CW'(CAPACITY), "count too large")

  `LRU_ASSERT(a_empty_zero, (out_valid && out_status == lru_pkg::ST_EMPTY) |-> (out_key_count == '0 && out_victim_key == '0), "empty result with keys")

  `LRU_ASSERT(a_full_count, (out_valid && out_status == lru_pkg::ST_FULL) |-> out_key_count == CW'(CAPACITY), "full result below capacity")

  `LRU_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_status) && $stable(out_victim_key) && $stable(out_key_count)), "stalled beat changed")

endmodule

bind lru_replacement_order lru_checker #(
  .CAPACITY (CAPACITY),
  .KEY_BITS (KEY_BITS)
) u_lru_checker (.*);

/* tb/lru_replacement_order_test.sv */
// Self-checking testbench of the LRU replacement list with random handshake pressure.
`timescale 1ns / 1ps

module lru_replacement_order_test;

  localparam int CAP        = lru_pkg::CAPACITY_DEF;
  localparam int KEYW       = lru_pkg::KEY_BITS_DEF;
  localparam int CW         = $clog2(CAP + 1);
  localparam int RAND_ITEMS = 1000;
  localparam int POOL_SIZE  = 20;
  localparam int LIMIT      = 400000;

  typedef struct packed {
    lru_pkg::mode_t  mode;
    logic [KEYW-1:0] key;
  } request_t;

  typedef struct packed {
    lru_pkg::status_t status;
    logic [KEYW-1:0]  victim;
    logic [CW-1:0]    count;
  } result_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [1:0]      in_mode = lru_pkg::MODE_NONE;
  logic [KEYW-1:0] in_key = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [1:0]      out_status;
  logic [KEYW-1:0] out_victim_key;
  logic [CW-1:0]   out_key_count;

  lru_replacement_order DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_victim_key (out_victim_key),
    .out_key_count  (out_key_count)
  );

  // Recency list kept by the testbench: slot 0 is the least recent key.
  logic [KEYW-1:0] recency_keys [CAP];
  int              keys_held = 0;

  request_t        pending_requests [$];
  result_t         expected_results [$];
  int              requests_accepted = 0;
  int              total_requests = 0;
  int              mismatches = 0;

  logic [KEYW-1:0] key_pool [POOL_SIZE];

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int locate_key(input logic [KEYW-1:0] k);
    int i;
    for (i = 0; i < keys_held; i++) begin
      if (recency_keys[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic void drop_slot(input int pos);
    int i;
    for (i = pos; i + 1 < keys_held; i++) recency_keys[i] = recency_keys[i + 1];
    keys_held--;
  endfunction

  function automatic void add_most_recent(input logic [KEYW-1:0] k);
    recency_keys[keys_held] = k;
    keys_held++;
  endfunction

  // Apply one accepted request to the recency list and queue its result.
  function automatic void update_recency(input lru_pkg::mode_t m, input logic [KEYW-1:0] k);
    int      pos;
    result_t r;
    r.status = lru_pkg::ST_OK;
    r.victim = '0;
    case (m)
      lru_pkg::MODE_TOUCH: begin
        pos = locate_key(k);
        if (pos >= 0) begin
          drop_slot(pos);
          add_most_recent(k);
        end else if (keys_held >= CAP) begin
          r.status = lru_pkg::ST_FULL;
        end else begin
          add_most_recent(k);
        end
      end
      lru_pkg::MODE_VICTIM: begin
        if (keys_held == 0) begin
          r.status = lru_pkg::ST_EMPTY;
        end else begin
          r.victim = recency_keys[0];
          drop_slot(0);
        end
      end
      lru_pkg::MODE_ERASE: begin
        pos = locate_key(k);
        if (pos >= 0) drop_slot(pos);
        else r.status = lru_pkg::ST_NOT_FOUND;
      end
      default: ;
    endcase
    r.count = CW'(keys_held);
    expected_results.push_back(r);
  endfunction

  function automatic void report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH @%0t: %s", $realtime, what);
  endfunction

  function automatic void queue_request(input lru_pkg::mode_t m, input logic [KEYW-1:0] k);
    request_t r;
    r.mode = m;
    r.key  = k;
    pending_requests.push_back(r);
  endfunction

  function automatic logic [KEYW-1:0] pick_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (roll < 95) return $urandom;
    return (roll[0]) ? '1 : '0;
  endfunction

  // Phases lean toward filling, draining or a balanced mix so that both the full and the
  // empty corners are reached often.
  function automatic void build_random_traffic();
    int made;
    int phase_len;
    int touch_pct;
    int victim_pct;
    int erase_pct;
    int roll;
    int i;
    made = 0;
    for (i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    while (made < RAND_ITEMS) begin
      phase_len = $urandom_range(20, 80);
      case ($urandom_range(0, 2))
        0: begin touch_pct = 70; victim_pct = 12; erase_pct = 14; end
        1: begin touch_pct = 25; victim_pct = 40; erase_pct = 30; end
        default: begin touch_pct = 45; victim_pct = 25; erase_pct = 25; end
      endcase
      for (i = 0; i < 4; i++) key_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
      for (i = 0; i < phase_len && made < RAND_ITEMS; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < touch_pct)
          queue_request(lru_pkg::MODE_TOUCH, pick_key());
        else if (roll < touch_pct + victim_pct)
          queue_request(lru_pkg::MODE_VICTIM, $urandom);
        else if (roll < touch_pct + victim_pct + erase_pct)
          queue_request(lru_pkg::MODE_ERASE, pick_key());
        else
          queue_request(lru_pkg::MODE_NONE, $urandom);
        made++;
      end
    end
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int       burst_left = 1;
  int       gap_left = 0;
  request_t next_req;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        update_recency(lru_pkg::mode_t'(in_mode), in_key);
        requests_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          next_req = pending_requests.pop_front();
          in_valid <= 1'b1;
          in_mode  <= next_req.mode;
          in_key   <= next_req.key;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall style is redrawn at random whenever the low six bits of the tick are zero.
  int          stall_tick = 0;
  int          stall_style = 0;
  logic [31:0] tick_bits;

  always @(posedge clk) begin
    stall_tick++;
    tick_bits = stall_tick;
    if (tick_bits[5:0] == 6'd0) stall_style = $urandom_range(0, 3);
    case (stall_style)
      0: out_ready <= 1'b1;
      1: out_ready <= tick_bits[0];
      2: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= (tick_bits[3:0] >= 4'd12);
    endcase
  end

  // Result checker.
  result_t head_result;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected beat: status %0d victim %h count %0d",
                                  out_status, out_victim_key, out_key_count));
      end else begin
        head_result = expected_results.pop_front();
        if (out_status !== head_result.status)
          report_mismatch($sformatf("status expected %0d got %0d",
                                    head_result.status, out_status));
        if (out_victim_key !== head_result.victim)
          report_mismatch($sformatf("victim_key expected %h got %h",
                                    head_result.victim, out_victim_key));
        if (out_key_count !== head_result.count)
          report_mismatch($sformatf("key_count expected %0d got %0d",
                                    head_result.count, out_key_count));
      end
    end
  end

  initial begin
    int i;
    // Directed corners: empty store, extreme keys, unused mode, fill to full.
    queue_request(lru_pkg::MODE_VICTIM, '1);
    queue_request(lru_pkg::MODE_ERASE, 32'h1234_5678);
    queue_request(lru_pkg::MODE_NONE, '1);
    queue_request(lru_pkg::MODE_TOUCH, '0);
    queue_request(lru_pkg::MODE_TOUCH, '1);
    queue_request(lru_pkg::MODE_TOUCH, '0);
    for (i = 0; i < CAP - 2; i++)
      queue_request(lru_pkg::MODE_TOUCH, 32'h0000_0001 << (i * 2 + 1));
    queue_request(lru_pkg::MODE_TOUCH, 32'hA5A5_A5A5);
    queue_request(lru_pkg::MODE_TOUCH, '1);
    queue_request(lru_pkg::MODE_VICTIM, '0);
    queue_request(lru_pkg::MODE_ERASE, '1);
    queue_request(lru_pkg::MODE_ERASE, '1);
    build_random_traffic();
    total_requests = pending_requests.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (requests_accepted < total_requests || expected_results.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    while (expected_results.size() > 0) begin
      head_result = expected_results.pop_front();
      report_mismatch($sformatf("missing beat: status %0d victim %h count %0d",
                                head_result.status, head_result.victim, head_result.count));
    end

    if (mismatches == 0) begin
      $display("lru_replacement_order verification clean");
    end else begin
      $display("lru_replacement_order verification failed");
    end
    $finish;
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("lru_replacement_order verification failed");
    $finish;
  end

endmodule
